>>> hdl/next_smooth_fft_size_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef NEXT_SMOOTH_FFT_SIZE_DEFINES_SVH
`define NEXT_SMOOTH_FFT_SIZE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/nss_pkg.sv
package nss_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int RADIX_SLOTS = 6;
   localparam int REG_COUNT   = 6;
   localparam int RADIX_W     = 8;
   localparam int REG_IDX_W   = $clog2(REG_COUNT);
   localparam int CSR_INDEX_W = REG_IDX_W;
   localparam int SLOT_W      = ($clog2(RADIX_SLOTS + 1) > $clog2(REG_COUNT + 1)) ?
                                $clog2(RADIX_SLOTS + 1) : $clog2(REG_COUNT + 1);
   localparam int DIV_CNT_W   = $clog2(LENGTH_BITS + 1);
   localparam int USER_W      = 2;
   localparam int USER_BAD    = 0;
   localparam int USER_OOR    = 1;

   typedef logic [LENGTH_BITS-1:0] length_type;
   typedef logic [RADIX_W-1:0]     radix_type;
   typedef radix_type              radix_array_type [REG_COUNT];

   localparam length_type LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam radix_type  RADIX_MIN  = radix_type'(2);

   localparam radix_array_type RADIX_RESET = '{
      radix_type'(7), radix_type'(6), radix_type'(5),
      radix_type'(4), radix_type'(3), radix_type'(2)
   };

   typedef struct packed {
      logic       start;
      length_type dividend;
      radix_type  divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      length_type quotient;
      logic       rem_zero;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CAND = 5'b00010,
      ST_SLOT = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

endpackage

>>> hdl/nss_csr.sv
module nss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nss_pkg::RADIX_W-1:0]       csr_wdata,
   output nss_pkg::radix_array_type          radix
);

   nss_pkg::radix_array_type radix_ff;

   assign csr_ready = 1'b1;
   assign radix     = radix_ff;

   // Drop writes to indexes past the last register.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= nss_pkg::RADIX_RESET;
      end else if (csr_valid && (int'(csr_index) < nss_pkg::REG_COUNT)) begin
         radix_ff[csr_index] <= csr_wdata;
      end
   end

endmodule

>>> hdl/nss_div.sv
module nss_div (
   input  logic                 clock,
   input  logic                 reset,
   input  nss_pkg::div_req_type div_req,
   output nss_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff,  busy_in;
   logic                            done_ff,  done_in;
   logic [nss_pkg::DIV_CNT_W-1:0]   cnt_ff,   cnt_in;
   nss_pkg::length_type             quo_ff,   quo_in;
   nss_pkg::radix_type              rem_ff,   rem_in;
   nss_pkg::radix_type              dvs_ff,   dvs_in;
   logic [nss_pkg::RADIX_W:0]       trial;
   logic [nss_pkg::RADIX_W:0]       diff;
   logic                            fits;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial   = {rem_ff, quo_ff[nss_pkg::LENGTH_BITS-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = nss_pkg::DIV_CNT_W'(nss_pkg::LENGTH_BITS);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[nss_pkg::LENGTH_BITS-2:0], fits};
         rem_in = fits ? diff[nss_pkg::RADIX_W-1:0] : trial[nss_pkg::RADIX_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == nss_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);

endmodule

>>> hdl/next_smooth_fft_size.sv
// Next smooth transform length.
// req_ carries a requested length; rsp_ returns the smallest length at or above it
// whose factors all come from the radix list (radix registers in order, ended by a
// value below 2). A zero request returns length 0 with bad_request set; a search
// that runs past the largest length returns all ones with out_of_range set.
// csr_ writes one radix register per word; write only while the block is idle.
// Timing: one request at a time, req_tready is high only while idle. Each
// candidate length passes through ST_CAND and ST_SLOT plus one trial division per
// radix step; each division runs through the shared restoring divider, one quotient
// bit a cycle, and returns to ST_SLOT when done. The number of candidates tried is
// set by the gap to the next smooth length. An empty radix list or a zero request
// goes from idle straight to ST_HOLD without a search.
// The result sits in an output register, so a finished search is parked until
// rsp_tready frees that register; a stalled receiver holds the block in its last
// step. Reset clears the sequencer and output valid and loads the default radix
// list 7, 6, 5, 4, 3, 2.
`include "next_smooth_fft_size_defines.svh"

module next_smooth_fft_size (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] requested_length
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [15:0] chosen_length
   output logic [1:0]                        rsp_tuser,   // [0] bad_request, [1] out_of_range
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nss_pkg::RADIX_W-1:0]       csr_wdata
);

   nss_pkg::radix_array_type          radix;
   nss_pkg::div_req_type              div_req;
   nss_pkg::div_rsp_type              div_rsp;

   nss_pkg::state_type                state_ff, state_in;
   nss_pkg::length_type               cand_ff,  cand_in;
   nss_pkg::length_type               rest_ff,  rest_in;
   logic [nss_pkg::SLOT_W-1:0]        slot_ff,  slot_in;
   nss_pkg::length_type               req_ff,   req_in;
   nss_pkg::length_type               res_len_ff, res_len_in;
   logic                              res_bad_ff, res_bad_in;
   logic                              res_oor_ff, res_oor_in;
   nss_pkg::length_type               out_len_ff, out_len_in;
   logic [nss_pkg::USER_W-1:0]        out_user_ff, out_user_in;
   logic                              out_valid_ff, out_valid_in;

   nss_pkg::radix_type                radix_cur;
   logic                              slot_end;
   logic                              req_fire;
   logic                              out_load;

   nss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .radix     (radix)
   );

   nss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == nss_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == nss_pkg::ST_HOLD) && (!out_valid_ff || rsp_tready);

   // Slots past the register file read as end of list.
   always_comb begin
      if (int'(slot_ff) < nss_pkg::REG_COUNT) begin
         radix_cur = radix[slot_ff[nss_pkg::REG_IDX_W-1:0]];
      end else begin
         radix_cur = '0;
      end
      slot_end = (int'(slot_ff) >= nss_pkg::RADIX_SLOTS) || (radix_cur < nss_pkg::RADIX_MIN) ||
                 (rest_ff == nss_pkg::length_type'(1));
   end

   // Sequencer: walk candidates upward, strip each radix with repeated trial divisions.
   always_comb begin
      state_in         = state_ff;
      cand_in          = cand_ff;
      rest_in          = rest_ff;
      slot_in          = slot_ff;
      req_in           = req_ff;
      res_len_in       = res_len_ff;
      res_bad_in       = res_bad_ff;
      res_oor_in       = res_oor_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rest_ff;
      div_req.divisor  = radix_cur;
      case (state_ff)
         nss_pkg::ST_IDLE: begin
            if (req_fire) begin
               req_in     = req_tdata;
               cand_in    = req_tdata;
               res_bad_in = 1'b0;
               res_oor_in = 1'b0;
               if (req_tdata == '0) begin
                  res_len_in = '0;
                  res_bad_in = 1'b1;
                  state_in   = nss_pkg::ST_HOLD;
               end else if (radix[0] < nss_pkg::RADIX_MIN) begin
                  // empty list: nothing is smooth, so the search runs out
                  res_len_in = nss_pkg::LENGTH_MAX;
                  res_oor_in = 1'b1;
                  state_in   = nss_pkg::ST_HOLD;
               end else begin
                  state_in = nss_pkg::ST_CAND;
               end
            end
         end
         nss_pkg::ST_CAND: begin
            rest_in = cand_ff;
            slot_in = '0;
            if (cand_ff < nss_pkg::length_type'(2)) begin
               // length one is never smooth; skip it
               cand_in = cand_ff + 1'b1;
            end else begin
               state_in = nss_pkg::ST_SLOT;
            end
         end
         nss_pkg::ST_SLOT: begin
            if (slot_end) begin
               if (rest_ff == nss_pkg::length_type'(1)) begin
                  res_len_in = cand_ff;
                  state_in   = nss_pkg::ST_HOLD;
               end else if (cand_ff == nss_pkg::LENGTH_MAX) begin
                  res_len_in = nss_pkg::LENGTH_MAX;
                  res_oor_in = 1'b1;
                  state_in   = nss_pkg::ST_HOLD;
               end else begin
                  cand_in  = cand_ff + 1'b1;
                  state_in = nss_pkg::ST_CAND;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = nss_pkg::ST_DIV;
            end
         end
         nss_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               // exact: keep dividing by this radix; otherwise advance to the next one
               if (div_rsp.rem_zero) begin
                  rest_in = div_rsp.quotient;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
               state_in = nss_pkg::ST_SLOT;
            end
         end
         nss_pkg::ST_HOLD: begin
            if (out_load) begin
               state_in = nss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nss_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: load on a finished search, drop when the receiver takes the word.
   always_comb begin
      out_len_in   = out_len_ff;
      out_user_in  = out_user_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_len_in                    = res_len_ff;
         out_user_in                   = '0;
         out_user_in[nss_pkg::USER_BAD] = res_bad_ff;
         out_user_in[nss_pkg::USER_OOR] = res_oor_ff;
         out_valid_in                  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nss_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      rest_ff     <= rest_in;
      slot_ff     <= slot_in;
      req_ff      <= req_in;
      res_len_ff  <= res_len_in;
      res_bad_ff  <= res_bad_in;
      res_oor_ff  <= res_oor_in;
      out_len_ff  <= out_len_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_len_ff;
   assign rsp_tuser  = out_user_ff;

   `NSS_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_tvalid,
      !(rsp_tuser[nss_pkg::USER_BAD] && rsp_tuser[nss_pkg::USER_OOR]),
      "both error flags set on one result")
   `NSS_ASSERT_NOW(a_result_not_below_request, clock, reset,
      out_load && !res_bad_ff, res_len_ff >= req_ff,
      "chosen length below requested length")
   `NSS_ASSERT_NOW(a_div_operands, clock, reset, div_req.start,
      (radix_cur >= nss_pkg::RADIX_MIN) && (rest_ff > nss_pkg::length_type'(1)),
      "trial division issued with a spent remainder or an invalid radix")
   `NSS_ASSERT_NEXT(a_div_start_waits, clock, reset, div_req.start,
      state_ff == nss_pkg::ST_DIV,
      "sequencer did not wait for the divider")

endmodule

>>> bench/next_smooth_fft_size_tb.sv
module next_smooth_fft_size_tb;

   import nss_pkg::*;

   localparam int          CLK_PERIOD      = 8;
   localparam int unsigned LEN_TOP         = (1 << LENGTH_BITS) - 1;
   localparam longint      WATCHDOG_CYCLES = 40_000_000;
   localparam int          DRAIN_LIMIT     = 200_000;
   localparam int          TAIL_CYCLES     = 64;
   localparam int          PHASE_COUNT     = 8;
   localparam int          SPAN_LIMIT      = 64;
   localparam int          MAX_REPORTS     = 10;

   // Register indexes used by name in the radix plans.
   localparam int REG_RADIX_A = 0;
   localparam int REG_RADIX_B = 1;

   // Small primes, largest first: slot 0 sits in the low byte.
   localparam logic [REG_COUNT*RADIX_W-1:0] PRIME_LIST =
      {8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13};

   // Radix settings walked by the phases; the first one is the reset list.
   typedef enum int {
      LIST_RESET,
      LIST_EMPTY,
      LIST_WIDE,
      LIST_POW2,
      LIST_PRIMES,
      LIST_RANDOM
   } list_kind_t;

   // One expected result word, plus the request it answers for reporting.
   typedef struct packed {
      length_type asked;
      length_type chosen;
      logic       bad_request;
      logic       out_of_range;
   } size_result_t;

   // Directed row: a request and, where obvious, its typed-in answer.
   typedef struct packed {
      length_type   len;
      logic         typed;
      size_result_t want;
   } probe_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [15:0]            req_tdata;    // [15:0] requested_length
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;    // [15:0] chosen_length
   logic [1:0]             rsp_tuser;    // [0] bad_request, [1] out_of_range
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [RADIX_W-1:0]     csr_wdata;

   // Shadow of the radix registers and the smooth-length map derived from it.
   radix_type    radix_shadow [REG_COUNT];
   bit           smooth_map [0:LEN_TOP];
   length_type   smooth_list [$];
   size_result_t pending_sizes [$];
   probe_t       probes [$];

   int  error_count    = 0;
   int  requests_sent  = 0;
   int  words_checked  = 0;
   int  bad_seen       = 0;
   int  oor_seen       = 0;
   int  settings_used  = 1;
   int  sink_hold      = 0;
   bit  src_steady     = 1'b0;
   bit  snk_steady     = 1'b0;

   next_smooth_fft_size u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void flag_error(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", what);
   endfunction

   // Divide the length fully by each radix in list order; smooth if 1 remains.
   // The list ends at the first radix below 2, and length 1 never qualifies.
   function automatic bit is_smooth_length(int unsigned len);
      int unsigned rest;
      int unsigned r;
      int          slot;
      rest = len;
      if (len < 2) return 1'b0;
      for (slot = 0; slot < RADIX_SLOTS; slot++) begin
         if (slot >= REG_COUNT) break;
         r = radix_shadow[slot];
         if (r < RADIX_MIN || rest == 1) break;
         while (rest % r == 0) rest = rest / r;
      end
      return rest == 1;
   endfunction

   // Rebuild the map once per radix setting so each prediction is a scan.
   task automatic rebuild_smooth_map();
      int unsigned n;
      smooth_list.delete();
      for (n = 0; n <= LEN_TOP; n++) begin
         smooth_map[n] = is_smooth_length(n);
         if (smooth_map[n]) smooth_list.push_back(length_type'(n));
      end
   endtask

   // Smallest smooth length at or above the request; zero is rejected and a
   // search that runs off the top saturates with the range flag set.
   function automatic size_result_t predict_size(length_type req);
      size_result_t res;
      int unsigned  cand;
      res = '0;
      res.asked = req;
      if (req == '0) begin
         res.bad_request = 1'b1;
         return res;
      end
      for (cand = req; cand <= LEN_TOP; cand++) begin
         if (smooth_map[cand]) begin
            res.chosen = length_type'(cand);
            return res;
         end
      end
      res.chosen       = LENGTH_MAX;
      res.out_of_range = 1'b1;
      return res;
   endfunction

   function automatic probe_t row(length_type len, logic typed, length_type chosen,
                                  logic bad, logic oor);
      probe_t p;
      p.len                 = len;
      p.typed               = typed;
      p.want.asked          = len;
      p.want.chosen         = chosen;
      p.want.bad_request    = bad;
      p.want.out_of_range   = oor;
      return p;
   endfunction

   function automatic radix_type planned_radix(list_kind_t kind, int slot);
      int unsigned roll;
      case (kind)
         LIST_EMPTY:  return (slot == REG_RADIX_A) ? radix_type'(0) : radix_type'(8'hFF);
         LIST_WIDE:   return radix_type'(8'hFF);
         LIST_POW2: begin
            if (slot == REG_RADIX_A) return radix_type'(2);
            if (slot == REG_RADIX_B) return radix_type'(1);
            return radix_type'(7);
         end
         LIST_PRIMES: return PRIME_LIST[slot*RADIX_W +: RADIX_W];
         default: begin
            // Mostly small radices, now and then a list end or a wide radix.
            roll = $urandom_range(0, 15);
            if (roll == 0) return radix_type'($urandom_range(0, 1));
            if (roll == 1) return radix_type'($urandom_range(13, 255));
            return radix_type'($urandom_range(2, 12));
         end
      endcase
   endfunction

   // Present one length, hold it until taken, then queue its expected word.
   // Enter and leave at a falling edge; valid stays high for the caller.
   task automatic send_request(length_type len, size_result_t want);
      int unsigned pause;
      pause = src_steady ? 0 : $urandom_range(0, 4);
      if (pause != 0) begin
         req_tvalid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = len;
      do @(posedge clock); while (!req_tready);
      pending_sizes.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   // One register write; indexes past the list must leave the shadow alone.
   task automatic write_radix(int idx, radix_type value);
      csr_valid = 1'b1;
      csr_index = CSR_INDEX_W'(idx);
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (idx < REG_COUNT) radix_shadow[idx] = value;
      @(negedge clock);
   endtask

   // Wait for every outstanding word, then let the block settle to idle.
   task automatic drain_results();
      while (pending_sizes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      size_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (pending_sizes.size() == 0) begin
            flag_error($sformatf("unexpected word: length %0d bad %0b oor %0b",
                                 rsp_tdata, rsp_tuser[USER_BAD], rsp_tuser[USER_OOR]));
         end else begin
            want = pending_sizes.pop_front();
            if (rsp_tdata !== want.chosen || rsp_tuser[USER_BAD] !== want.bad_request ||
                rsp_tuser[USER_OOR] !== want.out_of_range)
               flag_error($sformatf(
                  "request %0d: want length %0d bad %0b oor %0b, got %0d bad %0b oor %0b",
                  want.asked, want.chosen, want.bad_request, want.out_of_range,
                  rsp_tdata, rsp_tuser[USER_BAD], rsp_tuser[USER_OOR]));
            if (want.bad_request)  bad_seen++;
            if (want.out_of_range) oor_seen++;
         end
         // Draw the stall before the next word; switch steady stretches now and then.
         sink_hold = snk_steady ? 0 : $urandom_range(0, 4);
         if (words_checked % 30 == 0) snk_steady = ($urandom_range(0, 3) == 0);
      end
   end

   // Drive rsp_tready; also drop it at random while waiting so stalls hit
   // results that come back quickly.
   always @(negedge clock) begin
      if (sink_hold == 0 && !snk_steady && $urandom_range(0, 7) == 0)
         sink_hold = $urandom_range(1, 4);
      if (sink_hold != 0) begin
         rsp_tready = 1'b0;
         sink_hold--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   initial begin : stimulus
      int           phase;
      int           i;
      int           k;
      int           n;
      int           pick;
      int           tries;
      int           span;
      int unsigned  s;
      int unsigned  off;
      int           wait_cycles;
      int           item_count;
      bit           fits;
      length_type   len;
      list_kind_t   kind;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;

      // Reset list counts down from 7 to 2.
      for (k = 0; k < REG_COUNT; k++) radix_shadow[k] = radix_type'(7 - k);
      rebuild_smooth_map();

      // Directed rows under the reset list: zero, one, field extremes,
      // powers of two, lengths just below a smooth one, and the top end.
      probes.push_back(row(16'd0,     1'b1, 16'd0,     1'b1, 1'b0));
      probes.push_back(row(16'd1,     1'b1, 16'd2,     1'b0, 1'b0));
      probes.push_back(row(16'd2,     1'b1, 16'd2,     1'b0, 1'b0));
      probes.push_back(row(16'd7,     1'b1, 16'd7,     1'b0, 1'b0));
      probes.push_back(row(16'd11,    1'b1, 16'd12,    1'b0, 1'b0));
      probes.push_back(row(16'd13,    1'b1, 16'd14,    1'b0, 1'b0));
      probes.push_back(row(16'd17,    1'b1, 16'd18,    1'b0, 1'b0));
      probes.push_back(row(16'd256,   1'b1, 16'd256,   1'b0, 1'b0));
      probes.push_back(row(16'h8000,  1'b1, 16'h8000,  1'b0, 1'b0));
      probes.push_back(row(16'd49152, 1'b1, 16'd49152, 1'b0, 1'b0));
      probes.push_back(row(16'd60000, 1'b1, 16'd60000, 1'b0, 1'b0));
      probes.push_back(row(16'hFFFF,  1'b1, 16'hFFFF,  1'b0, 1'b1));
      probes.push_back(row(16'hFFFE,  1'b1, 16'hFFFF,  1'b0, 1'b1));
      probes.push_back(row(16'h00FF,  1'b0, '0, 1'b0, 1'b0));
      probes.push_back(row(16'h5555,  1'b0, '0, 1'b0, 1'b0));
      probes.push_back(row(16'hAAAA,  1'b0, '0, 1'b0, 1'b0));
      probes.push_back(row(16'hFF00,  1'b0, '0, 1'b0, 1'b0));
      probes.push_back(row(16'd1000,  1'b0, '0, 1'b0, 1'b0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (probes[i])
         send_request(probes[i].len,
                      probes[i].typed ? probes[i].want : predict_size(probes[i].len));

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         kind = (phase < LIST_RANDOM) ? list_kind_t'(phase) : LIST_RANDOM;

         // Reprogram only with the block idle: hold off until drained.
         if (kind != LIST_RESET) begin
            req_tvalid = 1'b0;
            drain_results();
            for (k = 0; k < REG_COUNT; k++) write_radix(k, planned_radix(kind, k));
            // Indexes past the list must be dropped; a list end here would show.
            for (k = REG_COUNT; k < (1 << CSR_INDEX_W); k++)
               write_radix(k, radix_type'($urandom_range(0, 1)));
            csr_valid = 1'b0;
            rebuild_smooth_map();
            settings_used++;
         end

         item_count = (kind == LIST_EMPTY) ? 40 : (kind == LIST_RESET) ? 100 : 90;
         for (n = 0; n < item_count; n++) begin
            if (n % 25 == 0) src_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               len = '0;
            end else if (pick < 15) begin
               // Close to the top, where searches may run off the range.
               len = length_type'(LEN_TOP - $urandom_range(0, SPAN_LIMIT));
            end else if (pick < 30) begin
               // Any length, as long as the search stays short.
               fits = 1'b0;
               for (tries = 0; tries < 8 && !fits; tries++) begin
                  len  = length_type'($urandom());
                  fits = (smooth_list.size() == 0);
                  for (span = 0; span <= SPAN_LIMIT && !fits; span++)
                     fits = (len + span > LEN_TOP) || smooth_map[len + span];
               end
               if (!fits) len = smooth_list[0];
            end else if (smooth_list.size() == 0) begin
               len = length_type'($urandom());
            end else begin
               // Land on or just below a smooth length anywhere in the range.
               s   = smooth_list[$urandom_range(0, smooth_list.size() - 1)];
               off = $urandom_range(0, 4);
               len = (s > off) ? length_type'(s - off) : length_type'(1);
            end
            send_request(len, predict_size(len));
         end
      end
      req_tvalid = 1'b0;

      // Drain with a bound, then give late or extra words time to show up.
      wait_cycles = 0;
      while (pending_sizes.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_sizes.size() != 0)
         flag_error($sformatf("%0d result words never arrived", pending_sizes.size()));

      $display("Checked %0d result words for %0d requests over %0d radix settings.",
               words_checked, requests_sent, settings_used);
      $display("Zero requests: %0d, searches past the largest length: %0d, errors: %0d.",
               bad_seen, oor_seen, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
